FILE: hw/rtl/nmea_line_checksum_checker_macros.svh
// Assertion macros used by the checksum checker's assertion module (nlcc_checker).
`ifndef NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH
`define NMEA_LINE_CHECKSUM_CHECKER_MACROS_SVH

// Same-cycle implication, reported as an error when it fails.
`define NLCC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("nlcc assertion failed");

// Next-cycle implication, reported as an error when it fails.
`define NLCC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("nlcc assertion failed");

`endif

FILE: hw/rtl/nlcc_pkg.sv
// Package with the constants, types and helper function of the checksum checker.
package nlcc_pkg;

   localparam logic [7:0] CH_DOLLAR    = 8'h24;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_NEWLINE   = 8'h0A;
   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_SKIP      = 8'hFF;
   localparam logic [7:0] CH_DIGIT_0   = 8'h30;
   localparam logic [7:0] CH_DIGIT_9   = 8'h39;
   localparam logic [7:0] CH_LOWER_A   = 8'h61;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_UPPER_A   = 8'h41;
   localparam logic [7:0] CH_UPPER_F   = 8'h46;
   localparam logic [7:0] COUNT_MAX    = 8'hFF;
   localparam logic [7:0] MAX_LEN_RESET = 8'd82;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_MISMATCH = 2'd2
   } status_type;

   typedef struct packed {
      logic       found;
      logic [3:0] value;
   } nibble_type;

   typedef struct packed {
      logic       dollar_seen;
      logic       star_seen;
      logic [7:0] running_xor;
      logic       hex_scan_open;
      logic       hex_digit_found;
      logic [7:0] hex_value;
      logic [7:0] stored_count;
   } line_state_type;

   function automatic nibble_type hex_nibble(input logic [7:0] c);
      nibble_type r;
      r.found = 1'b1;
      r.value = 4'd0;
      if (c inside {[CH_DIGIT_0:CH_DIGIT_9]}) begin
         r.value = 4'(c - CH_DIGIT_0);
      end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
         r.value = 4'(c - CH_LOWER_A + 8'd10);
      end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
         r.value = 4'(c - CH_UPPER_A + 8'd10);
      end else begin
         r.found = 1'b0;
      end
      return r;
   endfunction

endpackage

FILE: hw/rtl/nlcc_channels.sv
// Valid/ready channel interfaces for received bytes and line results.
interface nlcc_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface nlcc_result_if;
   logic                   valid;
   logic                   ready;
   nlcc_pkg::status_type   status;
   logic [7:0]             computed_checksum;
   logic [7:0]             received_checksum;
   logic [7:0]             line_length;

   modport source (output valid, output status, output computed_checksum,
                   output received_checksum, output line_length, input ready);
   modport sink (input valid, input status, input computed_checksum,
                 input received_checksum, input line_length, output ready);
endinterface

FILE: hw/rtl/nmea_line_checksum_checker.sv
// Top level of the NMEA line checksum checker.
// Serial bytes arrive one per beat on req_if and are framed into lines. A line
// ends at a newline or zero byte, or once the stored byte count reaches the
// limit held in the csr_ register, which the user must write only while the
// block is idle; the block does not enforce this. Bytes of 0xFF are dropped.
// Each finished line gives one beat on rsp_if with the status, both checksums
// and the stored length. A byte is taken into an input register and processed
// from there; a line's result is then registered and shown on rsp_if.
// Unless stalled as below, one byte is accepted every cycle; input and result
// registers part the two channels, so a byte can be taken while a result waits.
// If the receiver stalls with a result pending, bytes that end no line still
// pass through; a byte that would end the next line waits in the input
// register, and req_if.ready falls until the pending result is taken.
// Synchronous reset empties both registers, clears the line state and sets the
// length limit to 82.
module nmea_line_checksum_checker (
   input logic          clock,
   input logic          reset,
   nlcc_byte_if.sink    req_if,
   nlcc_result_if.source rsp_if,
   input logic          csr_wr_en,
   input logic [7:0]    csr_wr_data
);
   import nlcc_pkg::*;

   logic           byte_valid_ff, byte_valid_in;
   logic [7:0]     byte_ff;
   logic [7:0]     max_len_ff;
   line_state_type line_ff, line_in;
   logic           rsp_valid_ff, rsp_valid_in;
   status_type     status_ff, status_in;
   logic [7:0]     computed_ff, received_ff, length_ff;

   line_state_type absorbed, line_next;
   nibble_type     nib;
   logic [7:0]     limit;
   logic [7:0]     count_inc;
   logic           is_end, is_skip, finish_now, out_free, advance, req_take;

   always_comb begin
      limit   = (max_len_ff == 8'd0) ? 8'd1 : max_len_ff;
      is_end  = (byte_ff == CH_NUL) || (byte_ff == CH_NEWLINE);
      is_skip = (byte_ff == CH_SKIP);
      nib     = hex_nibble(byte_ff);

      absorbed = line_ff;
      if (line_ff.hex_scan_open) begin
         if (nib.found) begin
            absorbed.hex_value       = {line_ff.hex_value[3:0], nib.value};
            absorbed.hex_digit_found = 1'b1;
         end else begin
            absorbed.hex_scan_open = 1'b0;
         end
      end
      if (byte_ff == CH_STAR && !line_ff.star_seen) begin
         absorbed.star_seen     = 1'b1;
         absorbed.hex_scan_open = 1'b1;
      end else if (byte_ff == CH_DOLLAR && !line_ff.dollar_seen) begin
         absorbed.dollar_seen = 1'b1;
      end else if (line_ff.dollar_seen && !line_ff.star_seen) begin
         absorbed.running_xor = line_ff.running_xor ^ byte_ff;
      end
      count_inc = (line_ff.stored_count != COUNT_MAX) ? line_ff.stored_count + 8'd1
                                                      : line_ff.stored_count;
      absorbed.stored_count = count_inc;

      line_next  = (is_end || is_skip) ? line_ff : absorbed;
      finish_now = is_end || (!is_skip && (count_inc >= limit));

      out_free = !rsp_valid_ff || rsp_if.ready;
      advance  = byte_valid_ff && (!finish_now || out_free);

      req_if.ready  = !byte_valid_ff || advance;
      req_take      = req_if.valid && req_if.ready;
      byte_valid_in = req_take || (byte_valid_ff && !advance);

      line_in = line_ff;
      if (advance) begin
         line_in = finish_now ? '0 : line_next;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      if (advance && finish_now) begin
         rsp_valid_in = 1'b1;
      end

      if (!line_next.dollar_seen || !line_next.star_seen || !line_next.hex_digit_found) begin
         status_in = STATUS_INVALID;
      end else if (line_next.hex_value != line_next.running_xor) begin
         status_in = STATUS_MISMATCH;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         line_ff       <= '0;
         max_len_ff    <= MAX_LEN_RESET;
      end else begin
         byte_valid_ff <= byte_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         line_ff       <= line_in;
         if (csr_wr_en) begin
            max_len_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         byte_ff <= req_if.data_byte;
      end
      if (advance && finish_now) begin
         status_ff   <= status_in;
         computed_ff <= line_next.running_xor;
         received_ff <= line_next.hex_value;
         length_ff   <= line_next.stored_count;
      end
   end

   assign rsp_if.valid             = rsp_valid_ff;
   assign rsp_if.status            = status_ff;
   assign rsp_if.computed_checksum = computed_ff;
   assign rsp_if.received_checksum = received_ff;
   assign rsp_if.line_length       = length_ff;

endmodule

FILE: hw/rtl/nlcc_checker.sv
// Port-level assertions for the checksum checker and the bind that attaches them.
`include "nmea_line_checksum_checker_macros.svh"

module nlcc_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input nlcc_pkg::status_type rsp_status,
   input logic [7:0]           rsp_computed,
   input logic [7:0]           rsp_received,
   input logic [7:0]           rsp_length
);
   import nlcc_pkg::*;

   `NLCC_ASSERT_NEXT(a_reset_empties, clock, 1'b0, reset, !rsp_valid)
   `NLCC_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_computed) && $stable(rsp_received) && $stable(rsp_length))
   `NLCC_ASSERT_IMPLY(a_ok_matches, clock, reset, rsp_valid && rsp_status == STATUS_OK, rsp_computed == rsp_received)
   `NLCC_ASSERT_IMPLY(a_mismatch_differs, clock, reset, rsp_valid && rsp_status == STATUS_MISMATCH, rsp_computed != rsp_received)
   `NLCC_ASSERT_IMPLY(a_framed_length, clock, reset, rsp_valid && rsp_status != STATUS_INVALID, rsp_length >= 8'd3)

endmodule

bind nmea_line_checksum_checker nlcc_checker u_nlcc_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_status   (rsp_if.status),
   .rsp_computed (rsp_if.computed_checksum),
   .rsp_received (rsp_if.received_checksum),
   .rsp_length   (rsp_if.line_length)
);
